/* rtl/next_fit_word_allocator_memory_defines.svh */
// Assertion macros for the next-fit word allocator memory.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef NEXT_FIT_WORD_ALLOCATOR_MEMORY_DEFINES_SVH
`define NEXT_FIT_WORD_ALLOCATOR_MEMORY_DEFINES_SVH

`define NFWA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define NFWA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/nfwa_pkg.sv */
// Shared types and constants of the next-fit word allocator memory.
// No dependencies; used by the channel interfaces and the top level.
package nfwa_pkg;

  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 16;
  localparam int WORD_W   = 32;
  localparam int PID_IN_W = 8;
  localparam int STAT_W   = 2;

  localparam int unsigned WORD_BYTES = 4;
  localparam logic [WORD_W-1:0] FAIL_WORD = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ALLOC = 2'd2,
    KIND_FREE  = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_MISALIGNED = 2'd1,
    STAT_RANGE      = 2'd2,
    STAT_FULL       = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WORD,
    S_ALLOC,
    S_FREE
  } state_t;

endpackage

/* rtl/nfwa_chan_if.sv */
// Valid/ready channels for requests and results.
// Depends on nfwa_pkg for field widths.
interface nfwa_req_if;
  logic                                valid;
  logic                                ready;
  logic [nfwa_pkg::KIND_W-1:0]         kind;
  logic [nfwa_pkg::ADDR_W-1:0]         address;
  logic signed [nfwa_pkg::WORD_W-1:0]  value;
  logic [nfwa_pkg::PID_IN_W-1:0]       pid;

  modport source (output valid, kind, address, value, pid, input ready);
  modport sink   (input valid, kind, address, value, pid, output ready);
endinterface

interface nfwa_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [nfwa_pkg::STAT_W-1:0]         status;
  logic signed [nfwa_pkg::WORD_W-1:0]  data;

  modport source (output valid, status, data, input ready);
  modport sink   (input valid, status, data, output ready);
endinterface

/* rtl/nfwa_ram.sv */
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered and holds while the read enable is low. No dependencies.
module nfwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/next_fit_word_allocator_memory.sv */
// Read/write: the request is accepted, then the result is formed (reads take it from the word RAM read port).
// Alloc: the owner RAM is scanned one slot per cycle from the cursor.
// Dealloc: one owner RAM entry is checked per cycle, and freed if the request pid owns it.
// One request is in flight at a time; a finished result waits in the output register.
// Reset (rst_n, synchronous) starts a pass over every slot that zeroes both RAMs; no request
// is accepted until it ends.
`include "next_fit_word_allocator_memory_defines.svh"

module next_fit_word_allocator_memory #(
  parameter int SLOTS    = 256,
  parameter int PID_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  nfwa_req_if.sink      in_req,
  nfwa_rsp_if.source    out_rsp
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int OWN_W  = PID_BITS + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [31:0] BYTE_SPAN = 32'(SLOTS) * 32'(nfwa_pkg::WORD_BYTES);

  nfwa_pkg::state_t  state_r, state_nxt;
  nfwa_pkg::status_t stat_r, stat_nxt;
  nfwa_pkg::kind_t   kind_r, kind_nxt;
  logic [SLOT_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [SLOT_W-1:0]   cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]   start_r, start_nxt;
  logic [PID_BITS-1:0] pid_r, pid_nxt;
  logic                out_valid_r, out_valid_nxt;
  nfwa_pkg::status_t   out_status_r, out_status_nxt;
  logic [nfwa_pkg::WORD_W-1:0] out_data_r, out_data_nxt;

  logic                own_we, own_re;
  logic [SLOT_W-1:0]   own_waddr, own_raddr;
  logic [OWN_W-1:0]    own_wdata, own_rdata;
  logic                wst_we, wst_re;
  logic [SLOT_W-1:0]   wst_waddr;
  logic [nfwa_pkg::WORD_W-1:0] wst_wdata, wst_rdata;

  logic                accept, out_free, finish;
  nfwa_pkg::status_t   fin_status;
  logic [nfwa_pkg::WORD_W-1:0] fin_data;
  logic [31:0]         addr_ext;
  logic [SLOT_W-1:0]   acc_idx, chk_inc;
  nfwa_pkg::kind_t     in_kind;
  nfwa_pkg::status_t   acc_status;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] idx);
    slot_inc = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
  endfunction

  nfwa_ram #(.WIDTH(OWN_W), .DEPTH(SLOTS)) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .re    (own_re),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  nfwa_ram #(.WIDTH(nfwa_pkg::WORD_W), .DEPTH(SLOTS)) u_word_ram (
    .clk   (clk),
    .we    (wst_we),
    .waddr (wst_waddr),
    .wdata (wst_wdata),
    .re    (wst_re),
    .raddr (acc_idx),
    .rdata (wst_rdata)
  );

  assign in_req.ready = (state_r == nfwa_pkg::S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign in_kind      = nfwa_pkg::kind_t'(in_req.kind);
  assign addr_ext     = 32'(in_req.address);
  assign acc_idx      = addr_ext[SLOT_W+1:2];
  assign chk_inc      = slot_inc(chk_idx_r);

  always_comb begin
    if (addr_ext[1:0] != 2'b00) begin
      acc_status = nfwa_pkg::STAT_MISALIGNED;
    end else if (addr_ext >= BYTE_SPAN) begin
      acc_status = nfwa_pkg::STAT_RANGE;
    end else begin
      acc_status = nfwa_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfwa_pkg::S_CLEAR;
      chk_idx_r   <= '0;
      cnt_r       <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_idx_r   <= chk_idx_nxt;
      cnt_r       <= cnt_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r       <= stat_nxt;
    kind_r       <= kind_nxt;
    pid_r        <= pid_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    stat_nxt    = stat_r;
    kind_nxt    = kind_r;
    chk_idx_nxt = chk_idx_r;
    cnt_nxt     = cnt_r;
    start_nxt   = start_r;
    pid_nxt     = pid_r;
    own_we      = 1'b0;
    own_waddr   = chk_idx_r;
    own_wdata   = '0;
    own_re      = 1'b0;
    own_raddr   = chk_inc;
    wst_we      = 1'b0;
    wst_waddr   = chk_idx_r;
    wst_wdata   = '0;
    wst_re      = 1'b0;
    finish      = 1'b0;
    fin_status  = nfwa_pkg::STAT_OK;
    fin_data    = '0;

    case (state_r)
      nfwa_pkg::S_CLEAR: begin
        own_we      = 1'b1;
        wst_we      = 1'b1;
        chk_idx_nxt = chk_inc;
        if (chk_idx_r == LAST_SLOT) begin
          state_nxt = nfwa_pkg::S_IDLE;
        end
      end

      nfwa_pkg::S_IDLE: begin
        if (accept) begin
          pid_nxt  = PID_BITS'(32'(in_req.pid));
          kind_nxt = in_kind;
          case (in_kind)
            nfwa_pkg::KIND_READ, nfwa_pkg::KIND_WRITE: begin
              stat_nxt  = acc_status;
              state_nxt = nfwa_pkg::S_WORD;
              if (acc_status == nfwa_pkg::STAT_OK) begin
                if (in_kind == nfwa_pkg::KIND_READ) begin
                  wst_re = 1'b1;
                end else begin
                  wst_we    = 1'b1;
                  wst_waddr = acc_idx;
                  wst_wdata = in_req.value;
                end
              end
            end
            nfwa_pkg::KIND_ALLOC: begin
              own_re      = 1'b1;
              own_raddr   = start_r;
              chk_idx_nxt = start_r;
              cnt_nxt     = '0;
              state_nxt   = nfwa_pkg::S_ALLOC;
            end
            default: begin
              own_re      = 1'b1;
              own_raddr   = '0;
              chk_idx_nxt = '0;
              state_nxt   = nfwa_pkg::S_FREE;
            end
          endcase
        end
      end

      nfwa_pkg::S_WORD: begin
        if (out_free) begin
          finish     = 1'b1;
          fin_status = stat_r;
          if (stat_r != nfwa_pkg::STAT_OK) begin
            fin_data = nfwa_pkg::FAIL_WORD;
          end else if (kind_r == nfwa_pkg::KIND_READ) begin
            fin_data = wst_rdata;
          end
          state_nxt = nfwa_pkg::S_IDLE;
        end
      end

      nfwa_pkg::S_ALLOC: begin
        if (!own_rdata[0]) begin
          if (out_free) begin
            own_we     = 1'b1;
            own_wdata  = {pid_r, 1'b1};
            start_nxt  = chk_inc;
            finish     = 1'b1;
            fin_data   = 32'({chk_idx_r, 2'b00});
            state_nxt  = nfwa_pkg::S_IDLE;
          end
        end else if (cnt_r == LAST_SLOT) begin
          if (out_free) begin
            finish     = 1'b1;
            fin_status = nfwa_pkg::STAT_FULL;
            fin_data   = nfwa_pkg::FAIL_WORD;
            state_nxt  = nfwa_pkg::S_IDLE;
          end
        end else begin
          own_re      = 1'b1;
          chk_idx_nxt = chk_inc;
          cnt_nxt     = cnt_r + 1'b1;
        end
      end

      nfwa_pkg::S_FREE: begin
        if (own_rdata[0] && (own_rdata[OWN_W-1:1] == pid_r)) begin
          own_we = 1'b1;
        end
        if (chk_idx_r == LAST_SLOT) begin
          if (out_free) begin
            finish    = 1'b1;
            state_nxt = nfwa_pkg::S_IDLE;
          end
        end else begin
          own_re      = 1'b1;
          chk_idx_nxt = chk_inc;
        end
      end

      default: begin
        state_nxt = nfwa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    if (finish) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_status;
      out_data_nxt   = fin_data;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.status = out_status_r;
  assign out_rsp.data   = out_data_r;

  `NFWA_ASSERT_NEXT(a_one_in_flight, in_req.valid && in_req.ready, !in_req.ready, "second request taken while busy")
  `NFWA_ASSERT_IMPL(a_claim_free_slot, own_we && own_wdata[0], state_r == nfwa_pkg::S_ALLOC && !own_rdata[0], "alloc claimed an owned slot")
  `NFWA_ASSERT_IMPL(a_cursor_on_alloc, !$stable(start_r), $past(state_r) == nfwa_pkg::S_ALLOC, "cursor moved outside alloc")
  `NFWA_ASSERT_IMPL(a_store_on_accept, wst_we && state_r != nfwa_pkg::S_CLEAR, in_req.valid && in_req.ready, "word store written without a transfer")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for next_fit_word_allocator_memory: word reads and writes, next-fit
// slot claims and per-pid frees, checked against an in-bench prediction of memory and owners.
// Depends on nfwa_pkg and the nfwa_req_if / nfwa_rsp_if channel interfaces.
module tb_top;

  localparam int SLOTS        = 256;
  localparam int PID_BITS     = 8;
  localparam int ITEMS        = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = SLOTS + 16;
  localparam int WADDR_W      = nfwa_pkg::ADDR_W - 2;

  typedef struct packed {
    nfwa_pkg::status_t           status;
    logic [nfwa_pkg::WORD_W-1:0] data;
  } reply_t;

  class alloc_mem_board;
    reply_t                      due_replies[$];
    logic [PID_BITS:0]           owner_tag [SLOTS];
    logic [nfwa_pkg::WORD_W-1:0] word_mem [SLOTS];
    int unsigned       next_slot;
    int unsigned       mismatches, replies, requests;
    int unsigned       reads, writes, allocs, frees, rejects, full_hits;

    function new();
      foreach (owner_tag[i]) owner_tag[i] = '0;
      foreach (word_mem[i]) word_mem[i] = '0;
      next_slot = 0;
    endfunction

    function int unsigned pending();
      return due_replies.size();
    endfunction

    function void note_request(nfwa_pkg::kind_t kind, logic [nfwa_pkg::ADDR_W-1:0] addr,
                               logic [nfwa_pkg::WORD_W-1:0] val,
                               logic [nfwa_pkg::PID_IN_W-1:0] pid_in);
      reply_t              r;
      int unsigned         idx;
      int unsigned         n;
      bit                  hit;
      logic [PID_BITS-1:0] pid;
      pid      = pid_in[PID_BITS-1:0];
      r.status = nfwa_pkg::STAT_OK;
      r.data   = '0;
      requests++;
      case (kind)
        nfwa_pkg::KIND_READ, nfwa_pkg::KIND_WRITE: begin
          if (kind == nfwa_pkg::KIND_READ) reads++;
          else writes++;
          if (addr[1:0] != 2'b00) begin
            r.status = nfwa_pkg::STAT_MISALIGNED;
            r.data   = nfwa_pkg::FAIL_WORD;
            rejects++;
          end else if (addr >= SLOTS * nfwa_pkg::WORD_BYTES) begin
            r.status = nfwa_pkg::STAT_RANGE;
            r.data   = nfwa_pkg::FAIL_WORD;
            rejects++;
          end else begin
            idx = addr / nfwa_pkg::WORD_BYTES;
            if (kind == nfwa_pkg::KIND_READ) r.data = word_mem[idx];
            else word_mem[idx] = val;
          end
        end
        nfwa_pkg::KIND_ALLOC: begin
          allocs++;
          hit      = 1'b0;
          r.status = nfwa_pkg::STAT_FULL;
          r.data   = nfwa_pkg::FAIL_WORD;
          for (n = 0; n < SLOTS && !hit; n++) begin
            idx = (next_slot + n) % SLOTS;
            if (!owner_tag[idx][0]) begin
              owner_tag[idx] = {pid, 1'b1};
              next_slot      = (idx + 1) % SLOTS;
              r.status       = nfwa_pkg::STAT_OK;
              r.data         = idx * nfwa_pkg::WORD_BYTES;
              hit            = 1'b1;
            end
          end
          if (!hit) full_hits++;
        end
        default: begin
          frees++;
          foreach (owner_tag[i]) begin
            if (owner_tag[i][0] && owner_tag[i][PID_BITS:1] == pid) owner_tag[i] = '0;
          end
        end
      endcase
      due_replies.push_back(r);
    endfunction

    function void check_reply(logic [nfwa_pkg::STAT_W-1:0] status,
                              logic [nfwa_pkg::WORD_W-1:0] data);
      reply_t r;
      replies++;
      if (due_replies.size() == 0) begin
        mismatches++;
        $display("%0t: reply with nothing outstanding: status %0d data %h",
                 $time, status, data);
        return;
      end
      r = due_replies.pop_front();
      if (status !== r.status) begin
        mismatches++;
        $display("%0t: status mismatch: expected %s (%0d), got %0d",
                 $time, r.status.name(), r.status, status);
      end
      if (data !== r.data) begin
        mismatches++;
        $display("%0t: data mismatch: expected %h, got %h", $time, r.data, data);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_gaps;
  bit   hold_reply;
  int unsigned items_sent;
  alloc_mem_board board = new();

  nfwa_req_if req_ch();
  nfwa_rsp_if rsp_ch();

  next_fit_word_allocator_memory #(
    .SLOTS    (SLOTS),
    .PID_BITS (PID_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_req(nfwa_pkg::kind_t kind, logic [nfwa_pkg::ADDR_W-1:0] addr,
                          logic [nfwa_pkg::WORD_W-1:0] val,
                          logic [nfwa_pkg::PID_IN_W-1:0] pid);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.kind    <= kind;
    req_ch.address <= addr;
    req_ch.value   <= val;
    req_ch.pid     <= pid;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_request(kind, addr, val, pid);
    items_sent++;
  endtask

  task automatic drain_replies();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [nfwa_pkg::ADDR_W-1:0] pick_address();
    int unsigned r;
    logic [nfwa_pkg::ADDR_W-1:0] a;
    r = $urandom_range(0, 9);
    if (r < 3) a = {WADDR_W'($urandom_range(0, 15)), 2'b00};
    else if (r < 7) a = {WADDR_W'($urandom_range(0, SLOTS - 1)), 2'b00};
    else if (r < 8) a = {WADDR_W'($urandom_range(0, SLOTS - 1)), 2'($urandom_range(1, 3))};
    else a = nfwa_pkg::ADDR_W'($urandom);
    return a;
  endfunction

  task automatic send_random();
    int unsigned r;
    nfwa_pkg::kind_t kind;
    logic [nfwa_pkg::PID_IN_W-1:0] pid;
    r = $urandom_range(0, 99);
    if (r < 30) kind = nfwa_pkg::KIND_READ;
    else if (r < 60) kind = nfwa_pkg::KIND_WRITE;
    else if (r < 88) kind = nfwa_pkg::KIND_ALLOC;
    else kind = nfwa_pkg::KIND_FREE;
    pid = ($urandom_range(0, 3) == 0) ? nfwa_pkg::PID_IN_W'($urandom)
                                       : nfwa_pkg::PID_IN_W'($urandom_range(0, 7));
    send_req(kind, pick_address(), $urandom, pid);
  endtask

  task automatic fill_and_release();
    repeat (SLOTS + 6) send_req(nfwa_pkg::KIND_ALLOC, nfwa_pkg::ADDR_W'($urandom), $urandom,
                                nfwa_pkg::PID_IN_W'($urandom_range(0, 3)));
    send_req(nfwa_pkg::KIND_READ, pick_address(), $urandom, nfwa_pkg::PID_IN_W'($urandom));
    send_req(nfwa_pkg::KIND_WRITE, pick_address(), $urandom, nfwa_pkg::PID_IN_W'($urandom));
    for (int p = 0; p < 4; p++) begin
      send_req(nfwa_pkg::KIND_FREE, nfwa_pkg::ADDR_W'($urandom), $urandom,
               nfwa_pkg::PID_IN_W'(p));
    end
  endtask

  initial begin : reply_sink
    int unsigned gap;
    rsp_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_reply) begin
        gap        = HOLD_CYCLES;
        hold_reply = 1'b0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 9);
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      board.check_reply(rsp_ch.status, rsp_ch.data);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d replies outstanding",
             $time, quiet, board.pending());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    rst_n          = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.kind    = nfwa_pkg::KIND_READ;
    req_ch.address = '0;
    req_ch.value   = '0;
    req_ch.pid     = '0;
    no_gaps        = 1'b0;
    hold_reply     = 1'b0;
    items_sent     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_req(nfwa_pkg::KIND_READ,  16'h0000, 32'h0000_0000, 8'h00);
    send_req(nfwa_pkg::KIND_WRITE, 16'h0000, 32'h7FFF_FFFF, 8'h00);
    send_req(nfwa_pkg::KIND_READ,  16'h0000, 32'h0000_0000, 8'h00);
    send_req(nfwa_pkg::KIND_WRITE, 16'h03FC, 32'h8000_0000, 8'hFF);
    send_req(nfwa_pkg::KIND_READ,  16'h03FC, 32'hFFFF_FFFF, 8'h00);
    send_req(nfwa_pkg::KIND_WRITE, 16'h0001, 32'h1234_5678, 8'h00);
    send_req(nfwa_pkg::KIND_READ,  16'h0002, 32'h0000_0000, 8'h00);
    send_req(nfwa_pkg::KIND_READ,  16'hFFFF, 32'h0000_0000, 8'h00);
    send_req(nfwa_pkg::KIND_WRITE, 16'h0400, 32'hDEAD_BEEF, 8'h00);
    send_req(nfwa_pkg::KIND_READ,  16'hFFFC, 32'h0000_0000, 8'h00);
    send_req(nfwa_pkg::KIND_WRITE, 16'h8000, 32'hFFFF_FFFF, 8'h00);
    send_req(nfwa_pkg::KIND_READ,  16'h0000, 32'h0000_0000, 8'h00);
    send_req(nfwa_pkg::KIND_ALLOC, 16'h0000, 32'h0000_0000, 8'h00);
    send_req(nfwa_pkg::KIND_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_req(nfwa_pkg::KIND_ALLOC, 16'h0000, 32'h0000_0000, 8'h00);
    send_req(nfwa_pkg::KIND_FREE,  16'h0000, 32'h0000_0000, 8'h00);
    send_req(nfwa_pkg::KIND_ALLOC, 16'h0000, 32'h0000_0000, 8'h07);
    send_req(nfwa_pkg::KIND_FREE,  16'h0000, 32'h0000_0000, 8'h63);
    send_req(nfwa_pkg::KIND_FREE,  16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_req(nfwa_pkg::KIND_WRITE, 16'h0008, 32'hFFFF_FFFF, 8'h00);
    send_req(nfwa_pkg::KIND_READ,  16'h0008, 32'h0000_0000, 8'h00);
    send_req(nfwa_pkg::KIND_WRITE, 16'h0004, 32'h0000_0000, 8'h00);
    send_req(nfwa_pkg::KIND_READ,  16'h0004, 32'h0000_0000, 8'h00);
    send_req(nfwa_pkg::KIND_READ,  16'h03FC, 32'h0000_0000, 8'h00);
    drain_replies();

    repeat (450) send_random();
    fill_and_release();

    // hold the result side while requests keep coming
    hold_reply = 1'b1;
    repeat (300) send_random();
    drain_replies();

    no_gaps = 1'b1;
    repeat (300) send_random();
    no_gaps = 1'b0;
    fill_and_release();

    while (items_sent < ITEMS) send_random();
    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d reads, %0d writes, %0d allocs, %0d frees.",
             board.requests, board.reads, board.writes, board.allocs, board.frees);
    $display("%0d accesses rejected, %0d allocs on a full table, %0d replies checked.",
             board.rejects, board.full_hits, board.replies);
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
